### sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int VAL_W      = 8;
  localparam int CNT_W      = 5;

  typedef logic [1:0] act_t;
  localparam act_t ACT_INSERT = 2'd0;
  localparam act_t ACT_SEARCH = 2'd1;
  localparam act_t ACT_DELETE = 2'd2;

  typedef logic [1:0] res_t;
  localparam res_t RES_DONE      = 2'd0;
  localparam res_t RES_FOUND     = 2'd1;
  localparam res_t RES_NOT_FOUND = 2'd2;
  localparam res_t RES_FULL      = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE
  } op_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
    op_t  op;
    res_t res;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic found;
    logic full;
  } sts_t;

endpackage

### sv/sle_datapath.sv
// ----------------------------------------------------------------------------
// sle_datapath
// Sorted register array with per-cell compare, insert shift-up and
// delete shift-down, entry count and result register.
// ----------------------------------------------------------------------------
module sle_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sle_pkg::cmd_t                     cmd,
  output sle_pkg::sts_t                     sts,
  input  sle_pkg::act_t                     in_action,
  input  logic signed [sle_pkg::VAL_W-1:0]  in_value,
  output sle_pkg::res_t                     out_status,
  output logic [sle_pkg::CNT_W-1:0]         out_count
);

  localparam int D = sle_pkg::LIST_DEPTH;

  logic signed [sle_pkg::VAL_W-1:0] vals_r [D];
  logic signed [sle_pkg::VAL_W-1:0] vals_nxt [D];
  logic signed [sle_pkg::VAL_W-1:0] val_r;
  sle_pkg::act_t                    act_r;
  logic [sle_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [D-1:0]                     lt, eq, lt_r;
  logic                             found_r, full_r;
  sle_pkg::res_t                    status_r;
  logic [sle_pkg::CNT_W-1:0]        count_r;

  // per-cell compare; cells past the count never match
  always_comb begin
    for (int i = 0; i < D; i++) begin
      lt[i] = (sle_pkg::CNT_W'(i) < cnt_r) && (vals_r[i] < val_r);
      eq[i] = (sle_pkg::CNT_W'(i) < cnt_r) && (vals_r[i] == val_r);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < D; i++) vals_nxt[i] = vals_r[i];
    if (cmd.commit) begin
      case (cmd.op)
        sle_pkg::OP_INSERT: begin
          cnt_nxt = cnt_r + 1'b1;
          vals_nxt[0] = lt_r[0] ? vals_r[0] : val_r;
          for (int i = 1; i < D; i++) begin
            if (lt_r[i]) begin
              vals_nxt[i] = vals_r[i];
            end else if (lt_r[i-1]) begin
              vals_nxt[i] = val_r;
            end else begin
              vals_nxt[i] = vals_r[i-1];
            end
          end
        end
        sle_pkg::OP_DELETE: begin
          cnt_nxt = cnt_r - 1'b1;
          for (int i = 0; i < D - 1; i++) begin
            if (!lt_r[i]) vals_nxt[i] = vals_r[i+1];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      val_r <= in_value;
    end
    if (cmd.compare) begin
      lt_r    <= lt;
      found_r <= |eq;
      full_r  <= (cnt_r == sle_pkg::CNT_W'(D));
    end
    if (cmd.commit) begin
      status_r <= cmd.res;
      count_r  <= cnt_nxt;
    end
    for (int i = 0; i < D; i++) vals_r[i] <= vals_nxt[i];
  end

  assign sts.act   = act_r;
  assign sts.found = found_r;
  assign sts.full  = full_r;

  assign out_status = status_r;
  assign out_count  = count_r;

endmodule

### sv/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Request sequencer: load, compare, commit; owns the result valid flag.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  sle_pkg::sts_t sts,
  output sle_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd = '{load: 1'b0, compare: 1'b0, commit: 1'b0,
            op: sle_pkg::OP_NONE, res: sle_pkg::RES_DONE};
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (sts.act)
      sle_pkg::ACT_INSERT: begin
        if (sts.full) begin
          cmd.res = sle_pkg::RES_FULL;
        end else begin
          cmd.op = sle_pkg::OP_INSERT;
        end
      end
      sle_pkg::ACT_SEARCH: begin
        cmd.res = sts.found ? sle_pkg::RES_FOUND : sle_pkg::RES_NOT_FOUND;
      end
      sle_pkg::ACT_DELETE: begin
        if (sts.found) begin
          cmd.op = sle_pkg::OP_DELETE;
        end else begin
          cmd.res = sle_pkg::RES_NOT_FOUND;
        end
      end
      default: ;
    endcase

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (!cmd.commit) cmd.op = sle_pkg::OP_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### sv/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded ascending sorted multiset of signed bytes with insert, search
// and delete requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one request per accepted beat (action, value). Insert puts
//   the value before the first held entry not smaller; search reports found
//   or not found; delete removes the first equal entry. Action code 3 is a
//   no-op that returns done and the current count.
//   Output stream: exactly one result per request (status, entry count
//   after the request), held in an output register until taken.
//   Timing: a request is accepted in the idle state, compared against all
//   cells in the compare state and committed in the update state, where the
//   result is registered; a new request is taken only after that commit. The
//   load/compare/commit sequencer sets this order.
//   The next request can be accepted while the previous result still waits;
//   commit of its result waits until the output register is free.
//   Reset empties the list (count zero) and drops any pending result.
//   A stalled receiver holds the result and, after one more request, stalls
//   the input side.
// ----------------------------------------------------------------------------
module sorted_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] action, [9:2] value, [15:10] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [6:2] entry_count, [7] zero
);

  sle_pkg::cmd_t                     cmd;
  sle_pkg::sts_t                     sts;
  sle_pkg::res_t                     out_status;
  logic [sle_pkg::CNT_W-1:0]         out_count;
  logic signed [sle_pkg::VAL_W-1:0]  in_value;

  assign in_value = $signed(in_tdata[9:2]);

  sle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sle_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (in_tdata[1:0]),
    .in_value   (in_value),
    .out_status (out_status),
    .out_count  (out_count)
  );

  assign out_tdata = {1'b0, out_count, out_status};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:2] <= sle_pkg::CNT_W'(sle_pkg::LIST_DEPTH)))
    else $error("entry count beyond list depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == sle_pkg::RES_FULL)
      |-> (out_tdata[6:2] == sle_pkg::CNT_W'(sle_pkg::LIST_DEPTH)))
    else $error("full reported with list not full");

endmodule

### dv/tb_sorted_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_engine
// Self-checking stream testbench for the sorted list engine.
// Requests are sent on the input stream with random gaps. A predictor keeps
// its own sorted copy of the list and queues the expected status and count
// of each accepted request. Every result taken from the output stream is
// compared with the oldest queued expectation. The list is filled, refused,
// drained and churned, and the receiver stalls long enough to back up input.
// ----------------------------------------------------------------------------
module tb_sorted_list_engine;

  localparam sle_pkg::act_t ACT_UNUSED   = 2'd3;
  localparam int            STALL_CYCLES = 200;
  localparam int            IDLE_LIMIT   = 1000;
  localparam int            DRAIN_CYCLES = 20;
  localparam int            MAX_PRINTS   = 30;

  typedef struct packed {
    sle_pkg::res_t             status;
    logic [sle_pkg::CNT_W-1:0] count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  // predictor state
  logic signed [sle_pkg::VAL_W-1:0] list_vals [sle_pkg::LIST_DEPTH];
  int                               list_len = 0;
  list_result_t                     pending_results[$];

  int  error_count = 0;
  int  request_count = 0;
  int  result_count = 0;
  int  full_count = 0;
  int  found_count = 0;
  int  peak_len = 0;
  int  quiet_cycles = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  int  stall_req = 0;
  int  stall_ack = 0;
  int  stall_left = 0;

  sorted_list_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < sle_pkg::LIST_DEPTH; i++) list_vals[i] = '0;
  end

  // apply one request to the list copy and return its result
  function automatic list_result_t apply_request(input sle_pkg::act_t act,
                                                 input logic signed [sle_pkg::VAL_W-1:0] val);
    list_result_t r;
    int pos;
    int k;
    pos = 0;
    while (pos < list_len && list_vals[pos] < val) pos++;
    r.status = sle_pkg::RES_DONE;
    case (act)
      sle_pkg::ACT_INSERT: begin
        if (list_len >= sle_pkg::LIST_DEPTH) begin
          r.status = sle_pkg::RES_FULL;
        end else begin
          for (k = list_len; k > pos; k--) list_vals[k] = list_vals[k-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      sle_pkg::ACT_SEARCH: begin
        r.status = (pos < list_len && list_vals[pos] == val) ? sle_pkg::RES_FOUND
                                                             : sle_pkg::RES_NOT_FOUND;
      end
      sle_pkg::ACT_DELETE: begin
        if (pos < list_len && list_vals[pos] == val) begin
          for (k = pos; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
          list_len--;
        end else begin
          r.status = sle_pkg::RES_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.count = list_len[sle_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("ERROR: t=%0t result %0d %s got %0d want %0d",
               $realtime, result_count, what, got, want);
  endtask

  // monitor: check results first, then predict newly accepted requests
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result, data", out_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[1:0] !== want.status)
            flag_mismatch("status", out_tdata[1:0], want.status);
          if (out_tdata[6:2] !== want.count)
            flag_mismatch("entry_count", out_tdata[6:2], want.count);
          if (out_tdata[7] !== 1'b0)
            flag_mismatch("pad bit", out_tdata[7], 0);
          if (want.status == sle_pkg::RES_FULL) full_count++;
          if (want.status == sle_pkg::RES_FOUND) found_count++;
        end
        result_count++;
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_request(in_tdata[1:0], $signed(in_tdata[9:2])));
        request_count++;
        if (list_len > peak_len) peak_len = list_len;
      end
    end
  end

  // receiver: random holds, plus a long stall on request
  always @(posedge clk) begin
    if (stall_ack != stall_req) begin
      stall_ack  <= stall_req;
      stall_left <= STALL_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_idle_en && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input sle_pkg::act_t act,
                              input logic signed [sle_pkg::VAL_W-1:0] val);
    while (tx_idle_en && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {6'b0, 8'($urandom_range(255)), 2'($urandom_range(3))};
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic sle_pkg::act_t pick_action(input int insert_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return ACT_UNUSED;
    if (r < 3 + insert_pct) return sle_pkg::ACT_INSERT;
    return ($urandom_range(1) != 0) ? sle_pkg::ACT_SEARCH : sle_pkg::ACT_DELETE;
  endfunction

  // mostly values already held or near zero, so hits and duplicates are common
  function automatic logic signed [sle_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (list_len > 0 && r < 45) return list_vals[$urandom_range(list_len - 1)];
    if (r < 70) return sle_pkg::VAL_W'($urandom_range(8) - 4);
    return sle_pkg::VAL_W'($urandom_range(255));
  endfunction

  task automatic test_empty_and_ends();
    send_request(sle_pkg::ACT_SEARCH, -8'sd128);
    send_request(sle_pkg::ACT_DELETE, 8'sd5);
    send_request(sle_pkg::ACT_INSERT, 8'sd0);
    send_request(sle_pkg::ACT_INSERT, 8'sd127);
    send_request(sle_pkg::ACT_INSERT, -8'sd128);
    send_request(sle_pkg::ACT_INSERT, 8'sd0);
    send_request(sle_pkg::ACT_SEARCH, 8'sd0);
    send_request(sle_pkg::ACT_SEARCH, 8'sd1);
    send_request(sle_pkg::ACT_DELETE, -8'sd128);
    send_request(sle_pkg::ACT_DELETE, 8'sd127);
    send_request(sle_pkg::ACT_DELETE, 8'sd0);
    send_request(ACT_UNUSED, -8'sd1);
  endtask

  task automatic test_full_list();
    int i;
    for (i = 0; i < sle_pkg::LIST_DEPTH - 1; i++)
      send_request(sle_pkg::ACT_INSERT, sle_pkg::VAL_W'($urandom_range(255)));
    send_request(sle_pkg::ACT_INSERT, 8'sd42);
    send_request(sle_pkg::ACT_SEARCH, 8'sd0);
    send_request(sle_pkg::ACT_DELETE, 8'sd0);
    send_request(sle_pkg::ACT_INSERT, -8'sd128);
    send_request(sle_pkg::ACT_INSERT, 8'sd127);
  endtask

  task automatic test_random_traffic(input int n, input int insert_pct);
    int i;
    for (i = 0; i < n; i++) send_request(pick_action(insert_pct), pick_value());
  endtask

  task automatic test_output_stall();
    int i;
    tx_idle_en = 1'b0;
    stall_req <= stall_req + 1;
    for (i = 0; i < 24; i++) send_request(pick_action(50), pick_value());
    tx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_ends();
    test_full_list();
    test_random_traffic(250, 65);
    // back-to-back stretch, no gaps on either side
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    test_random_traffic(300, 45);
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    test_random_traffic(200, 25);
    test_output_stall();
    test_random_traffic(250, 50);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d requests, %0d results, %0d mismatches", request_count,
             result_count, error_count);
    $display("Summary: %0d full refusals, %0d search hits, peak list length %0d",
             full_count, found_count, peak_len);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
